// File: src/gbn_pkg.sv
package gbn_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SEQ_BITS     = 16;
  localparam int STATE_BITS   = SEQ_BITS + 1;
  localparam int WIN_BITS     = 7;
  localparam int SLOT_BITS    = 6;
  localparam int TOTAL_BITS   = 16;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int RC_CNT_BITS  = $clog2(STATE_BITS);

  localparam int CWND_DEFAULT = 4000;
  localparam int PACKET_BYTES = 1000;
  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(CWND_DEFAULT / PACKET_BYTES);

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_FIN_ACK = 2'd2;
  localparam logic [1:0] ACT_TIMEOUT = 2'd3;

  localparam logic [1:0] KIND_NEW  = 2'd0;
  localparam logic [1:0] KIND_RETX = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] KIND_FIN  = 2'd3;

  localparam logic [1:0] TMR_LEAVE   = 2'd0;
  localparam logic [1:0] TMR_RESTART = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL  = 1'b1;

  typedef struct packed {
    logic latch_item;
    logic cfg_write;
    logic do_setup;
    logic do_emit;
    logic rc_load;
    logic rc_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic single;
    logic burst_last;
    logic rc_done;
  } dp_status_t;

  function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] ws);
    logic [WIN_BITS-1:0] w;
    w = ws;
    if (ws == '0) begin
      w = WIN_BITS'(1);
    end else if (ws > WIN_BITS'(MAX_WINDOW)) begin
      w = WIN_BITS'(MAX_WINDOW);
    end
    return w;
  endfunction

  function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s,
                                                     input logic [WIN_BITS-1:0] w);
    logic [WIN_BITS-1:0] t;
    t = {1'b0, s} + WIN_BITS'(1);
    return (t == w) ? '0 : t[SLOT_BITS-1:0];
  endfunction

  // one restoring step of a remainder by the window
  function automatic logic [SLOT_BITS-1:0] rem_step(input logic [SLOT_BITS-1:0] r,
                                                     input logic b,
                                                     input logic [WIN_BITS-1:0] w);
    logic [WIN_BITS-1:0] t;
    t = {r, b};
    if (t >= w) begin
      t = t - w;
    end
    return t[SLOT_BITS-1:0];
  endfunction

endpackage

// File: src/go_back_n_sender_window.sv
// Go-Back-N sender window control.
// Input channel (in_valid/in_stall) carries one event: action and ack_seq.
// Output channel (out_valid/out_stall) carries transmit commands: packet_kind,
// seq_out, slot, timer_cmd, finished, and last on the final command of an event.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 is the window width, 1 is
// total_packets; write it only while no event is in progress.
// An event is accepted in the idle state and latched; the setup state
// decodes it once the output register is free. A single-command event
// loads its command into the output register there, and the block returns
// to idle to take a new event. A start or timeout burst of n commands goes
// on to the burst state, one command per cycle out of the output register
// while the output is not stalled. A window width write starts a slot
// recompute (one remainder bit per cycle); inputs stall meanwhile.
// Reset: window_base = next_to_send = 1, not closed, window width 4,
// total_packets 0, output empty.
// When the receiver stalls, the output register holds its command and the
// sequencer waits; the last command of an event may wait while a new event
// is accepted.
module go_back_n_sender_window (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [gbn_pkg::SEQ_BITS-1:0]        ack_seq,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          packet_kind,
  output logic [gbn_pkg::SEQ_BITS-1:0]        seq_out,
  output logic [gbn_pkg::SLOT_BITS-1:0]       slot,
  output logic [1:0]                          timer_cmd,
  output logic                                finished,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gbn_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import gbn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .status    (status),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  gbn_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .action      (action),
    .ack_seq     (ack_seq),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .packet_kind (packet_kind),
    .seq_out     (seq_out),
    .slot        (slot),
    .timer_cmd   (timer_cmd),
    .finished    (finished),
    .last        (last)
  );

endmodule

// File: src/gbn_ctrl.sv
module gbn_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               cfg_valid,
  input  logic [gbn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  gbn_pkg::dp_status_t                status,
  output logic                               in_stall,
  output logic                               cfg_ready,
  output gbn_pkg::dp_cmd_t                   cmd
);
  import gbn_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SETUP  = 2'd1;
  localparam logic [1:0] S_BURST  = 2'd2;
  localparam logic [1:0] S_RECALC = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       cfg_write;
  logic       in_take;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.cfg_write  = cfg_write;
    cmd.latch_item = in_take;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = S_SETUP;
        end else if (cfg_write && cfg_index == CFG_WINDOW) begin
          cmd.rc_load = 1'b1;
          state_next  = S_RECALC;
        end
      end
      S_SETUP: begin
        if (status.out_free) begin
          cmd.do_setup = 1'b1;
          state_next   = status.single ? S_IDLE : S_BURST;
        end
      end
      S_BURST: begin
        if (status.out_free) begin
          cmd.do_emit = 1'b1;
          if (status.burst_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_RECALC: begin
        cmd.rc_step = 1'b1;
        if (status.rc_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/gbn_dp.sv
module gbn_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  gbn_pkg::dp_cmd_t                    cmd,
  output gbn_pkg::dp_status_t                 status,
  input  logic [1:0]                          action,
  input  logic [gbn_pkg::SEQ_BITS-1:0]        ack_seq,
  input  logic [gbn_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gbn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [1:0]                          packet_kind,
  output logic [gbn_pkg::SEQ_BITS-1:0]        seq_out,
  output logic [gbn_pkg::SLOT_BITS-1:0]       slot,
  output logic [1:0]                          timer_cmd,
  output logic                                finished,
  output logic                                last
);
  import gbn_pkg::*;

  localparam int WIDE_BITS = STATE_BITS + 1;

  logic [WIN_BITS-1:0]    win_size, win_size_next;
  logic [TOTAL_BITS-1:0]  total_packets, total_packets_next;
  logic [STATE_BITS-1:0]  window_base, window_base_next;
  logic [STATE_BITS-1:0]  next_to_send, next_to_send_next;
  logic [SLOT_BITS-1:0]   base_slot, base_slot_next;
  logic [SLOT_BITS-1:0]   next_slot, next_slot_next;
  logic                   closed, closed_next;
  logic                   out_valid_next;

  logic [1:0]             act_r, act_r_next;
  logic [SEQ_BITS-1:0]    ack_r, ack_r_next;
  logic [STATE_BITS-1:0]  cur_seq, cur_seq_next;
  logic [SLOT_BITS-1:0]   cur_slot, cur_slot_next;
  logic [WIN_BITS-1:0]    remain, remain_next;
  logic                   burst_retx, burst_retx_next;
  logic                   first, first_next;
  logic [RC_CNT_BITS-1:0] rc_cnt, rc_cnt_next;
  logic [SLOT_BITS-1:0]   rc_base_rem, rc_base_rem_next;
  logic [SLOT_BITS-1:0]   rc_next_rem, rc_next_rem_next;

  logic [1:0]             o_kind;
  logic [STATE_BITS-1:0]  o_seq;
  logic [SLOT_BITS-1:0]   o_slot;
  logic [1:0]             o_timer;
  logic                   o_last;
  logic                   out_load;

  logic [WIN_BITS-1:0]    w;
  logic                   data_phase;
  logic [WIN_BITS-1:0]    start_cnt;
  logic [STATE_BITS-1:0]  base_inc;
  logic                   ack_match;
  logic [STATE_BITS-1:0]  outstanding;
  logic [WIN_BITS-1:0]    retx_cnt;
  logic                   room;
  logic [STATE_BITS-1:0]  base_m1;
  logic [STATE_BITS-1:0]  next_m1;
  logic                   single;

  assign w           = eff_window(win_size);
  assign data_phase  = !closed && (window_base <= {1'b0, total_packets});
  assign start_cnt   = (total_packets < {{(TOTAL_BITS-WIN_BITS){1'b0}}, w}) ?
                       total_packets[WIN_BITS-1:0] : w;
  assign base_inc    = window_base + STATE_BITS'(1);
  assign ack_match   = ({1'b0, ack_r} == window_base);
  assign outstanding = next_to_send - window_base;
  assign retx_cnt    = (outstanding > STATE_BITS'(MAX_WINDOW)) ?
                       WIN_BITS'(MAX_WINDOW) : outstanding[WIN_BITS-1:0];
  assign room        = ({1'b0, next_to_send} <
                        ({1'b0, base_inc} + {{(WIDE_BITS-WIN_BITS){1'b0}}, w}));
  assign base_m1     = window_base - STATE_BITS'(1);
  assign next_m1     = next_to_send - STATE_BITS'(1);

  assign single = !(((act_r == ACT_START) && (start_cnt != '0)) ||
                    ((act_r == ACT_TIMEOUT) && data_phase && (next_to_send > window_base)));

  assign status.out_free   = !out_valid || !out_stall;
  assign status.single     = single;
  assign status.burst_last = (remain == WIN_BITS'(1));
  assign status.rc_done    = (rc_cnt == '0);

  always_comb begin
    win_size_next      = win_size;
    total_packets_next = total_packets;
    window_base_next   = window_base;
    next_to_send_next  = next_to_send;
    base_slot_next     = base_slot;
    next_slot_next     = next_slot;
    closed_next        = closed;
    act_r_next         = act_r;
    ack_r_next         = ack_r;
    cur_seq_next       = cur_seq;
    cur_slot_next      = cur_slot;
    remain_next        = remain;
    burst_retx_next    = burst_retx;
    first_next         = first;
    rc_cnt_next        = rc_cnt;
    rc_base_rem_next   = rc_base_rem;
    rc_next_rem_next   = rc_next_rem;
    out_load           = 1'b0;
    o_kind             = KIND_NONE;
    o_seq              = '0;
    o_slot             = '0;
    o_timer            = TMR_LEAVE;
    o_last             = 1'b1;

    if (cmd.latch_item) begin
      act_r_next = action;
      ack_r_next = ack_seq;
    end

    if (cmd.cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW: win_size_next      = cfg_data[WIN_BITS-1:0];
        CFG_TOTAL:  total_packets_next = cfg_data[TOTAL_BITS-1:0];
        default:    win_size_next      = win_size;
      endcase
    end

    if (cmd.do_setup) begin
      out_load = single;
      unique case (act_r)
        ACT_START: begin
          window_base_next  = STATE_BITS'(1);
          next_to_send_next = STATE_BITS'(1);
          base_slot_next    = '0;
          next_slot_next    = '0;
          closed_next       = 1'b0;
          cur_seq_next      = STATE_BITS'(1);
          cur_slot_next     = '0;
          remain_next       = start_cnt;
          burst_retx_next   = 1'b0;
          first_next        = 1'b1;
          o_kind            = KIND_FIN;
          o_timer           = TMR_STOP;
        end
        ACT_FIN_ACK: begin
          closed_next = 1'b1;
          o_timer     = TMR_STOP;
        end
        ACT_ACK: begin
          if (data_phase) begin
            o_timer = TMR_RESTART;
            if (ack_match) begin
              window_base_next = base_inc;
              base_slot_next   = slot_inc(base_slot, w);
              if (base_inc > {1'b0, total_packets}) begin
                o_kind  = KIND_FIN;
                o_timer = TMR_STOP;
              end else if (room && (next_to_send <= {1'b0, total_packets})) begin
                o_kind            = KIND_NEW;
                o_seq             = next_to_send;
                o_slot            = next_slot;
                next_to_send_next = next_to_send + STATE_BITS'(1);
                next_slot_next    = slot_inc(next_slot, w);
              end else if (next_to_send <= base_inc) begin
                o_timer = TMR_STOP;
              end
            end
          end
        end
        ACT_TIMEOUT: begin
          if (data_phase) begin
            o_timer         = TMR_RESTART;
            cur_seq_next    = window_base;
            cur_slot_next   = base_slot;
            remain_next     = retx_cnt;
            burst_retx_next = 1'b1;
            first_next      = 1'b1;
          end
        end
        default: o_timer = TMR_LEAVE;
      endcase
    end

    if (cmd.do_emit) begin
      out_load      = 1'b1;
      o_kind        = burst_retx ? KIND_RETX : KIND_NEW;
      o_seq         = cur_seq;
      o_slot        = cur_slot;
      o_last        = (remain == WIN_BITS'(1));
      if (burst_retx ? o_last : first) begin
        o_timer = TMR_RESTART;
      end
      cur_seq_next  = cur_seq + STATE_BITS'(1);
      cur_slot_next = slot_inc(cur_slot, w);
      remain_next   = remain - WIN_BITS'(1);
      first_next    = 1'b0;
      if (!burst_retx) begin
        next_to_send_next = cur_seq + STATE_BITS'(1);
        next_slot_next    = slot_inc(cur_slot, w);
      end
    end

    // slot positions follow a new window width
    if (cmd.rc_load) begin
      rc_cnt_next      = RC_CNT_BITS'(STATE_BITS - 1);
      rc_base_rem_next = '0;
      rc_next_rem_next = '0;
    end
    if (cmd.rc_step) begin
      rc_base_rem_next = rem_step(rc_base_rem, base_m1[rc_cnt], w);
      rc_next_rem_next = rem_step(rc_next_rem, next_m1[rc_cnt], w);
      if (rc_cnt == '0) begin
        base_slot_next = rc_base_rem_next;
        next_slot_next = rc_next_rem_next;
      end else begin
        rc_cnt_next = rc_cnt - RC_CNT_BITS'(1);
      end
    end

    out_valid_next = out_load ? 1'b1 : (out_stall ? out_valid : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size      <= WINDOW_RESET;
      total_packets <= '0;
      window_base   <= STATE_BITS'(1);
      next_to_send  <= STATE_BITS'(1);
      base_slot     <= '0;
      next_slot     <= '0;
      closed        <= 1'b0;
      rc_cnt        <= '0;
      out_valid     <= 1'b0;
    end else begin
      win_size      <= win_size_next;
      total_packets <= total_packets_next;
      window_base   <= window_base_next;
      next_to_send  <= next_to_send_next;
      base_slot     <= base_slot_next;
      next_slot     <= next_slot_next;
      closed        <= closed_next;
      rc_cnt        <= rc_cnt_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_r_next;
    ack_r       <= ack_r_next;
    cur_seq     <= cur_seq_next;
    cur_slot    <= cur_slot_next;
    remain      <= remain_next;
    burst_retx  <= burst_retx_next;
    first       <= first_next;
    rc_base_rem <= rc_base_rem_next;
    rc_next_rem <= rc_next_rem_next;
    if (out_load) begin
      packet_kind <= o_kind;
      seq_out     <= o_seq[SEQ_BITS-1:0];
      slot        <= o_slot;
      timer_cmd   <= o_timer;
      finished    <= closed_next;
      last        <= o_last;
    end
  end

endmodule

// File: src/gbn_checker.sv
module gbn_props (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          packet_kind,
  input logic [gbn_pkg::SEQ_BITS-1:0]        seq_out,
  input logic [gbn_pkg::SLOT_BITS-1:0]       slot,
  input logic [1:0]                          timer_cmd,
  input logic                                finished,
  input logic                                last
);
  import gbn_pkg::*;

  // one event at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while idle did not stall the next one");

  a_finished_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> packet_kind == KIND_NONE)
    else $error("closed transfer sent a packet");

  a_no_data_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (packet_kind == KIND_NONE || packet_kind == KIND_FIN)
      |-> seq_out == '0 && slot == '0)
    else $error("non-data command carries a sequence or slot");

  a_fin_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_kind == KIND_FIN |-> last && timer_cmd == TMR_STOP)
    else $error("fin packet not final or timer not stopped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(seq_out) && $stable(packet_kind))
    else $error("stalled command changed");

endmodule

bind go_back_n_sender_window gbn_props u_gbn_props (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .packet_kind (packet_kind),
  .seq_out     (seq_out),
  .slot        (slot),
  .timer_cmd   (timer_cmd),
  .finished    (finished),
  .last        (last)
);
